FILE: rtl/core/sitoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants for the signed integer to decimal ASCII formatter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_CHARS_DEF   = 11;

  // depth of the queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;  // '-'

  // shift-and-add-3 correction for one BCD digit
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  // decimal digits needed for an unsigned magnitude of the given width
  function automatic int bcd_digits(input int width);
    return ((width * 1233) >> 12) + 1;
  endfunction

endpackage

FILE: rtl/core/sitoa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_front
// Input side: splits the signed word into sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module sitoa_front import sitoa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   push,
  input  logic                   full,
  output logic [VALUE_WIDTH:0]   push_data   // {neg, magnitude}
);

  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;

  assign in_ready = !full && !rst;
  assign push     = in_valid && in_ready;

  // two's complement negate; the most negative value maps to 2^(W-1)
  assign neg = in_value[VALUE_WIDTH-1];
  assign mag = neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;

  assign push_data = {neg, mag};

endmodule

FILE: rtl/core/sitoa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module sitoa_queue import sitoa_pkg::*; #(
  parameter int WIDTH = VALUE_WIDTH_DEF + 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/sitoa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_back
// Bit-serial binary to BCD conversion, then character emit from the top digit.
// ----------------------------------------------------------------------------
module sitoa_back import sitoa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int MAX_CHARS   = MAX_CHARS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   not_empty,
  input  logic [VALUE_WIDTH:0]   pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   out_last
);

  localparam int NDIG  = bcd_digits(VALUE_WIDTH);
  localparam int BW    = 4 * NDIG;
  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int DIG_W = $clog2(NDIG);
  localparam int CHR_W = $clog2(MAX_CHARS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_SIGN  = 2'd2;
  localparam logic [1:0] ST_DIGIT = 2'd3;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] bin;
  logic [BW-1:0]          bcd;
  logic [BW-1:0]          bcd_adj;
  logic                   neg;
  logic                   started;
  logic [CNT_W-1:0]       cnt;
  logic [DIG_W-1:0]       dig_left;
  logic [CHR_W-1:0]       chars;
  logic [3:0]             top;
  logic                   can_load;
  logic                   skip;
  logic                   final_char;
  logic                   emit;

  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= BCD_ADJ_MIN) ?
                          bcd[4*d +: 4] + BCD_ADJ : bcd[4*d +: 4];
    end
  end

  assign top        = bcd[BW-1 -: 4];
  assign can_load   = !out_valid || out_ready;
  assign skip       = !started && (top == 4'd0) && (dig_left != '0);
  assign final_char = (dig_left == '0) || (chars == CHR_W'(MAX_CHARS - 1));
  assign pop        = (state == ST_IDLE) && not_empty;
  // a character goes into the output register this cycle
  assign emit       = can_load && (((state == ST_SIGN) && neg) ||
                                   ((state == ST_DIGIT) && !skip));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (not_empty) begin
            neg     <= pop_data[VALUE_WIDTH];
            bin     <= pop_data[VALUE_WIDTH-1:0];
            bcd     <= '0;
            cnt     <= '0;
            started <= 1'b0;
            state   <= ST_CONV;
          end
        end
        ST_CONV: begin
          {bcd, bin} <= {bcd_adj[BW-2:0], bin, 1'b0};
          cnt        <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(VALUE_WIDTH - 1)) begin
            dig_left <= DIG_W'(NDIG - 1);
            chars    <= '0;
            state    <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          if (!neg) begin
            state <= ST_DIGIT;
          end else if (can_load) begin
            out_char  <= CHAR_MINUS;
            out_last  <= 1'b0;
            chars     <= CHR_W'(1);
            state     <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (skip) begin
            bcd      <= {bcd[BW-5:0], 4'd0};
            dig_left <= dig_left - DIG_W'(1);
          end else if (can_load) begin
            out_char  <= CHAR_ZERO + CHAR_W'(top);
            out_last  <= final_char;
            started   <= 1'b1;
            bcd       <= {bcd[BW-5:0], 4'd0};
            dig_left  <= dig_left - DIG_W'(1);
            chars     <= chars + CHR_W'(1);
            if (final_char) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Signed integer to decimal ASCII text formatter.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis_*): one word per integer, two's complement value in
//   the low VALUE_WIDTH bits of s_axis_tdata.
//   Master stream (m_axis_*): one word per character, most significant first;
//   a leading '-' for negative values, no leading zeros, zero gives "0".
//   m_axis_tlast marks the final character of each number. Text longer than
//   MAX_CHARS is cut to its first MAX_CHARS characters.
// Operation:
//   The back end converts one value at a time: a load step, VALUE_WIDTH
//   shift-and-add-3 steps in the bit-serial BCD converter, a sign step, then
//   one step per BCD digit position (leading zeros are skipped one at a time).
//   A two-entry queue lets the input side take words while the back end works.
// Reset: rst (synchronous) empties the queue, idles the converter and drops
//   m_axis_tvalid. When the receiver stalls, the output register holds its
//   character and the converter waits to load its next character.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top import sitoa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int MAX_CHARS   = MAX_CHARS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // value
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [7:0]                            m_axis_tdata,  // text_char, zero pad
  output logic                                  m_axis_tlast   // last
);

  logic                   push;
  logic                   full;
  logic [VALUE_WIDTH:0]   push_data;
  logic                   pop;
  logic                   not_empty;
  logic [VALUE_WIDTH:0]   pop_data;
  logic [CHAR_W-1:0]      out_char;

  // sign/magnitude split on the way in
  sitoa_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_value  (s_axis_tdata[VALUE_WIDTH-1:0]),
    .push      (push),
    .full      (full),
    .push_data (push_data)
  );

  // decouples input acceptance from the slow conversion
  sitoa_queue #(
    .WIDTH (VALUE_WIDTH + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  // BCD conversion and character emit, with the output register
  sitoa_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_CHARS   (MAX_CHARS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (out_char),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {(8 - CHAR_W)'(0), out_char};

endmodule

FILE: rtl/core/sitoa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_checker
// Port-level checks on the formatter's output stream.
// ----------------------------------------------------------------------------
module sitoa_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // only '-' or a decimal digit, pad bits zero
  a_charset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata == 8'd45) ||
      ((m_axis_tdata >= 8'd48) && (m_axis_tdata <= 8'd57)))
    else $error("character out of range");

  // the sign never ends a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata == 8'd45) |-> !m_axis_tlast)
    else $error("minus sign flagged as last");

  // an accepted minus is not followed directly by another minus
  a_minus_then_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && (m_axis_tdata == 8'd45) |=>
      !(m_axis_tvalid && (m_axis_tdata == 8'd45)))
    else $error("two minus signs in a row");

  // reset drops the output
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii_top sitoa_checker u_sitoa_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
